### sv/assert_macros.svh
// assertion macros used by the tracer top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/cct_pkg.sv
// types, codes and direction helpers for the chain code boundary tracer
`timescale 1ns / 1ps
package cct_pkg;

   localparam int DEF_MAX_ROWS   = 256;
   localparam int DEF_MAX_COLS   = 256;
   localparam int DEF_PIXEL_BITS = 8;

   localparam int DIM_BITS       = 9;
   localparam int VALUE_BITS     = 8;
   localparam int KIND_BITS      = 2;
   localparam int DIR_BITS       = 3;
   localparam int CSR_INDEX_BITS = 2;

   // request operations
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   // response kinds
   localparam logic [KIND_BITS-1:0] KIND_WRITE_ACK = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_START     = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_CHAIN     = 2'd2;
   localparam logic [KIND_BITS-1:0] KIND_END       = 2'd3;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_ROWS = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_COLS = 2'd1;

   // freeman directions, counter-clockwise from east
   localparam logic [DIR_BITS-1:0] DIR_E  = 3'd0;
   localparam logic [DIR_BITS-1:0] DIR_NE = 3'd1;
   localparam logic [DIR_BITS-1:0] DIR_N  = 3'd2;
   localparam logic [DIR_BITS-1:0] DIR_NW = 3'd3;
   localparam logic [DIR_BITS-1:0] DIR_W  = 3'd4;
   localparam logic [DIR_BITS-1:0] DIR_SW = 3'd5;
   localparam logic [DIR_BITS-1:0] DIR_S  = 3'd6;
   localparam logic [DIR_BITS-1:0] DIR_SE = 3'd7;

   typedef struct packed {
      logic                  operation;
      logic [DIM_BITS-1:0]   pixel_row;
      logic [DIM_BITS-1:0]   pixel_col;
      logic [VALUE_BITS-1:0] pixel_value;
   } cct_req_type;

   typedef struct packed {
      logic [KIND_BITS-1:0]  kind;
      logic [VALUE_BITS-1:0] start_value;
      logic [DIM_BITS-1:0]   point_row;
      logic [DIM_BITS-1:0]   point_col;
      logic [DIR_BITS-1:0]   direction;
      logic                  last;
   } cct_rsp_type;

   // row after one move, rows grow downward
   function automatic logic [DIM_BITS-1:0] nb_row(input logic [DIM_BITS-1:0] r,
                                                  input logic [DIR_BITS-1:0] d);
      logic [DIM_BITS-1:0] res;
      case (d)
         DIR_NE, DIR_N, DIR_NW: res = r - 9'd1;
         DIR_SW, DIR_S, DIR_SE: res = r + 9'd1;
         default:               res = r;
      endcase
      return res;
   endfunction

   function automatic logic [DIM_BITS-1:0] nb_col(input logic [DIM_BITS-1:0] c,
                                                  input logic [DIR_BITS-1:0] d);
      logic [DIM_BITS-1:0] res;
      case (d)
         DIR_E, DIR_NE, DIR_SE: res = c + 9'd1;
         DIR_NW, DIR_W, DIR_SW: res = c - 9'd1;
         default:               res = c;
      endcase
      return res;
   endfunction

   // start of the next neighbour search, indexed by (dir + 7) mod 8
   function automatic logic [DIR_BITS-1:0] next_search(input logic [DIR_BITS-1:0] d);
      logic [DIR_BITS-1:0] res;
      case (d - 3'd1)
         3'd0:    res = DIR_S;
         3'd1:    res = DIR_E;
         3'd2:    res = DIR_E;
         3'd3:    res = DIR_N;
         3'd4:    res = DIR_N;
         3'd5:    res = DIR_W;
         3'd6:    res = DIR_W;
         default: res = DIR_S;
      endcase
      return res;
   endfunction

endpackage

### sv/cct_store.sv
// image store with one write and one registered read port, zeroed by a sweep after reset
`timescale 1ns / 1ps
module cct_store #(
   parameter int ADDR_BITS  = 16,
   parameter int PIXEL_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  logic [ADDR_BITS-1:0]  wr_addr,
   input  logic [PIXEL_BITS-1:0] wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_BITS-1:0]  rd_addr,
   output logic [PIXEL_BITS-1:0] rd_data,
   output logic                  busy
);

   localparam int DEPTH = 1 << ADDR_BITS;

   logic [PIXEL_BITS-1:0] mem [DEPTH];
   logic [PIXEL_BITS-1:0] rd_data_ff;
   logic                  clr_busy_ff, clr_busy_in;
   logic [ADDR_BITS-1:0]  clr_addr_ff, clr_addr_in;
   logic                  mem_we;
   logic [ADDR_BITS-1:0]  mem_waddr;
   logic [PIXEL_BITS-1:0] mem_wdata;

   // clear sweep walks every entry once
   assign clr_addr_in = clr_addr_ff + ADDR_BITS'(1);
   assign clr_busy_in = clr_busy_ff && (clr_addr_ff != '1);

   assign mem_we    = clr_busy_ff || wr_en;
   assign mem_waddr = clr_busy_ff ? clr_addr_ff : wr_addr;
   assign mem_wdata = clr_busy_ff ? '0 : wr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = clr_busy_ff;

endmodule

### sv/chain_code_boundary_tracer.sv
// top level of the 8-connected chain code boundary tracer
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Pixel writes (operation 0) store a value at a one-based row and column; every write is
// acknowledged with kind 0, writes outside MAX_ROWS x MAX_COLS are dropped, and any write
// restarts the trace. Trace steps (operation 1) return one response each: the first step
// raster-scans the rows_in_use x cols_in_use area for the first nonzero pixel and returns
// a start record (kind 1), later steps return one chain direction each (kind 2) with last
// set on the move back onto the start point, and kind 3 means no object, an isolated start
// pixel or a finished trace. Pixels outside the area in use read as zero. After reset the
// store is zeroed by a sweep over all 2**(clog2(MAX_ROWS)+clog2(MAX_COLS)) entries (65536
// at the default size) during which req_ready stays low; csr writes are taken at any time
// but are meant for an idle block. A write goes from accept to the finish state, which
// loads the response register once it is free. In a chain step one probe unit issues one
// neighbour read per cycle into the store's single registered read port and tests the data
// in the next cycle, up to eight probes. The first step scans one pixel per cycle the same
// way. The block takes one request at a time, but accepts the next one while a response
// still waits on rsp_ready.
module chain_code_boundary_tracer #(
   parameter int MAX_ROWS   = cct_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS   = cct_pkg::DEF_MAX_COLS,
   parameter int PIXEL_BITS = cct_pkg::DEF_PIXEL_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  cct_pkg::cct_req_type                 req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output cct_pkg::cct_rsp_type                 rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [cct_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [cct_pkg::DIM_BITS-1:0]         csr_wdata
);

   import cct_pkg::*;

   // store geometry: row and column fields side by side in the address
   localparam int ROW_BITS  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_BITS  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int ADDR_BITS = ROW_BITS + COL_BITS;
   localparam int EXT_BITS  = (PIXEL_BITS > VALUE_BITS) ? PIXEL_BITS : VALUE_BITS;

   // size registers after reset: 256 clamped to the maxima
   localparam int ROWS_RESET = (MAX_ROWS < 256) ? MAX_ROWS : 256;
   localparam int COLS_RESET = (MAX_COLS < 256) ? MAX_COLS : 256;

   // sequencer states
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_PROBE  = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   // trace phases
   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_TRACE = 2'd1;
   localparam logic [1:0] PH_DONE  = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [1:0]            phase_ff, phase_in;
   logic [DIM_BITS-1:0]   rows_ff, rows_in;
   logic [DIM_BITS-1:0]   cols_ff, cols_in;
   logic [DIM_BITS-1:0]   start_row_ff, start_row_in;
   logic [DIM_BITS-1:0]   start_col_ff, start_col_in;
   logic [DIM_BITS-1:0]   cur_row_ff, cur_row_in;
   logic [DIM_BITS-1:0]   cur_col_ff, cur_col_in;
   logic [DIR_BITS-1:0]   search_ff, search_in;
   logic                  mode_scan_ff, mode_scan_in;
   logic [DIM_BITS-1:0]   sc_row_ff, sc_row_in;
   logic [DIM_BITS-1:0]   sc_col_ff, sc_col_in;
   logic [DIR_BITS-1:0]   k_ff, k_in;
   logic                  iss_done_ff, iss_done_in;
   logic                  p_valid_ff, p_valid_in;
   logic                  p_in_ff, p_in_in;
   logic [DIM_BITS-1:0]   p_row_ff, p_row_in;
   logic [DIM_BITS-1:0]   p_col_ff, p_col_in;
   logic [DIR_BITS-1:0]   p_dir_ff, p_dir_in;
   cct_rsp_type           res_ff, res_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   cct_rsp_type           rsp_data_ff, rsp_data_in;

   logic                  req_fire;
   logic                  wr_in_range;
   logic                  st_wr_en;
   logic [ADDR_BITS-1:0]  st_wr_addr;
   logic [PIXEL_BITS-1:0] st_wr_data;
   logic                  st_rd_en;
   logic [ADDR_BITS-1:0]  st_rd_addr;
   logic [PIXEL_BITS-1:0] st_rd_data;
   logic                  st_busy;
   logic [EXT_BITS-1:0]   rd_ext;

   logic                  issue;
   logic [DIR_BITS-1:0]   dir_k;
   logic [DIM_BITS-1:0]   pr;
   logic [DIM_BITS-1:0]   pc;
   logic                  in_area;
   logic                  hit;
   logic                  miss;

   // 0 reads as 1, above the maximum saturates
   function automatic logic [DIM_BITS-1:0] clamp_size(input logic [DIM_BITS-1:0] v,
                                                      input int mx);
      logic [DIM_BITS-1:0] res;
      if (v == '0) begin
         res = 9'd1;
      end else if (32'(v) > mx) begin
         res = DIM_BITS'(mx);
      end else begin
         res = v;
      end
      return res;
   endfunction

   // ---------------------------------------------------------------- handshakes
   assign req_ready = (state_ff == ST_IDLE) && !st_busy;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------- pixel writes
   assign wr_in_range = (req_data.pixel_row != '0) && (32'(req_data.pixel_row) <= MAX_ROWS) &&
                        (req_data.pixel_col != '0) && (32'(req_data.pixel_col) <= MAX_COLS);
   assign st_wr_en    = req_fire && (req_data.operation == OP_WRITE) && wr_in_range;
   assign st_wr_addr  = {ROW_BITS'(req_data.pixel_row - 9'd1),
                         COL_BITS'(req_data.pixel_col - 9'd1)};
   assign st_wr_data  = PIXEL_BITS'(req_data.pixel_value);

   // ---------------------------------------------------------------- probe unit
   // one candidate pixel per cycle, from the raster counters or around the current point
   assign issue   = (state_ff == ST_PROBE) && !iss_done_ff;
   assign dir_k   = search_ff + 3'd1 + k_ff;
   assign pr      = mode_scan_ff ? sc_row_ff : nb_row(cur_row_ff, dir_k);
   assign pc      = mode_scan_ff ? sc_col_ff : nb_col(cur_col_ff, dir_k);
   // the zero frame and everything beyond the area in use read as zero
   assign in_area = (pr != '0) && (pc != '0) && (pr <= rows_ff) && (pc <= cols_ff);

   assign st_rd_en   = issue && in_area;
   assign st_rd_addr = {ROW_BITS'(pr - 9'd1), COL_BITS'(pc - 9'd1)};

   // probe stage, registered in step with the read data
   assign p_valid_in = issue;
   assign p_in_in    = in_area;
   assign p_row_in   = pr;
   assign p_col_in   = pc;
   assign p_dir_in   = dir_k;

   assign rd_ext = EXT_BITS'(st_rd_data);
   assign hit    = (state_ff == ST_PROBE) && p_valid_ff && p_in_ff && (st_rd_data != '0);
   assign miss   = (state_ff == ST_PROBE) && iss_done_ff && !p_valid_ff;

   // ---------------------------------------------------------------- size registers
   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_ROWS: rows_in = clamp_size(csr_wdata, MAX_ROWS);
            REG_COLS: cols_in = clamp_size(csr_wdata, MAX_COLS);
            default:  ;
         endcase
      end
   end

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      start_row_in = start_row_ff;
      start_col_in = start_col_ff;
      cur_row_in   = cur_row_ff;
      cur_col_in   = cur_col_ff;
      search_in    = search_ff;
      mode_scan_in = mode_scan_ff;
      sc_row_in    = sc_row_ff;
      sc_col_in    = sc_col_ff;
      k_in         = k_ff;
      iss_done_in  = iss_done_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_data.operation == OP_WRITE) begin
                  // any write restarts the trace
                  phase_in    = PH_IDLE;
                  res_in      = '0;
                  res_in.kind = KIND_WRITE_ACK;
                  state_in    = ST_FINISH;
               end else if (phase_ff == PH_IDLE) begin
                  mode_scan_in = 1'b1;
                  sc_row_in    = 9'd1;
                  sc_col_in    = 9'd1;
                  iss_done_in  = 1'b0;
                  state_in     = ST_PROBE;
               end else if (phase_ff == PH_TRACE) begin
                  mode_scan_in = 1'b0;
                  k_in         = '0;
                  iss_done_in  = 1'b0;
                  state_in     = ST_PROBE;
               end else begin
                  // step after the end of a trace
                  res_in      = '0;
                  res_in.kind = KIND_END;
                  state_in    = ST_FINISH;
               end
            end
         end
         ST_PROBE: begin
            if (issue) begin
               if (mode_scan_ff) begin
                  // raster order: columns inside rows
                  if (sc_col_ff >= cols_ff) begin
                     sc_col_in = 9'd1;
                     if (sc_row_ff >= rows_ff) begin
                        iss_done_in = 1'b1;
                     end else begin
                        sc_row_in = sc_row_ff + 9'd1;
                     end
                  end else begin
                     sc_col_in = sc_col_ff + 9'd1;
                  end
               end else begin
                  k_in = k_ff + 3'd1;
                  if (k_ff == 3'd7) begin
                     iss_done_in = 1'b1;
                  end
               end
            end
            if (hit) begin
               res_in = '0;
               if (mode_scan_ff) begin
                  start_row_in      = p_row_ff;
                  start_col_in      = p_col_ff;
                  cur_row_in        = p_row_ff;
                  cur_col_in        = p_col_ff;
                  search_in         = DIR_W;
                  phase_in          = PH_TRACE;
                  res_in.kind       = KIND_START;
                  res_in.start_value = rd_ext[VALUE_BITS-1:0];
                  res_in.point_row  = p_row_ff;
                  res_in.point_col  = p_col_ff;
               end else begin
                  cur_row_in       = p_row_ff;
                  cur_col_in       = p_col_ff;
                  search_in        = next_search(p_dir_ff);
                  res_in.kind      = KIND_CHAIN;
                  res_in.point_row = p_row_ff;
                  res_in.point_col = p_col_ff;
                  res_in.direction = p_dir_ff;
                  // back on the start point closes the boundary
                  if ((p_row_ff == start_row_ff) && (p_col_ff == start_col_ff)) begin
                     res_in.last = 1'b1;
                     phase_in    = PH_DONE;
                  end
               end
               state_in = ST_FINISH;
            end else if (miss) begin
               // no object, or an isolated start pixel
               phase_in    = PH_DONE;
               res_in      = '0;
               res_in.kind = KIND_END;
               state_in    = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // output register free or being emptied this cycle
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_IDLE;
         rows_ff      <= DIM_BITS'(ROWS_RESET);
         cols_ff      <= DIM_BITS'(COLS_RESET);
         start_row_ff <= '0;
         start_col_ff <= '0;
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         search_ff    <= DIR_W;
         mode_scan_ff <= 1'b0;
         sc_row_ff    <= '0;
         sc_col_ff    <= '0;
         k_ff         <= '0;
         iss_done_ff  <= 1'b1;
         p_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         start_row_ff <= start_row_in;
         start_col_ff <= start_col_in;
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         search_ff    <= search_in;
         mode_scan_ff <= mode_scan_in;
         sc_row_ff    <= sc_row_in;
         sc_col_ff    <= sc_col_in;
         k_ff         <= k_in;
         iss_done_ff  <= iss_done_in;
         p_valid_ff   <= p_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      p_in_ff     <= p_in_in;
      p_row_ff    <= p_row_in;
      p_col_ff    <= p_col_in;
      p_dir_ff    <= p_dir_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // ---------------------------------------------------------------- image store
   cct_store #(
      .ADDR_BITS  (ADDR_BITS),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data),
      .rd_en   (st_rd_en),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data),
      .busy    (st_busy)
   );

   // ---------------------------------------------------------------- assertions
   `ASSERT_IMPL(a_no_req_while_clearing, clock, reset, st_busy, !req_ready, "request taken during store clear")
   `ASSERT_NEXT(a_one_request_at_a_time, clock, reset, req_fire, !req_ready, "second request taken while busy")
   `ASSERT_IMPL(a_trace_point_valid, clock, reset, phase_ff == PH_TRACE, (cur_row_ff != '0) && (cur_col_ff != '0), "tracing from a frame point")
   `ASSERT_IMPL(a_last_only_on_chain, clock, reset, rsp_valid_ff && rsp_data_ff.last, rsp_data_ff.kind == KIND_CHAIN, "last flag outside a chain response")

endmodule

### sim/tb_chain_code_boundary_tracer.sv
// testbench for the chain code boundary tracer: directed and random requests against a predictor
`timescale 1ns / 1ps
module tb_chain_code_boundary_tracer;
   import cct_pkg::*;

   // run length: directed requests plus about 1400 random ones
   localparam int REQUEST_TARGET = 1425;

   // tracer walk phase as the predictor sees it
   typedef enum logic [1:0] {
      WALK_IDLE,
      WALK_ACTIVE,
      WALK_DONE
   } walk_phase_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   cct_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   cct_rsp_type rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = REG_ROWS;
   logic [DIM_BITS-1:0]       csr_wdata = '0;

   // predictor copy of the image store, area registers and walk position
   bit [VALUE_BITS-1:0] pixel_img [0:DEF_MAX_ROWS-1][0:DEF_MAX_COLS-1];
   int                  area_rows = DEF_MAX_ROWS;
   int                  area_cols = DEF_MAX_COLS;
   int                  origin_row = 0;
   int                  origin_col = 0;
   int                  here_row = 0;
   int                  here_col = 0;
   logic [DIR_BITS-1:0] probe_from = DIR_W;
   walk_phase_type      walk_phase = WALK_IDLE;

   // chain code responses still owed by the block, oldest first
   cct_rsp_type pending_codes[$];
   cct_rsp_type code_want;

   int          fail_count = 0;
   int          requests_sent = 0;
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct = 0;

   chain_code_boundary_tracer uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // hard stop in case the block hangs
   initial begin
      #50_000_000;
      $display("simulation failed");
      $finish;
   end

   // expected response for one accepted request, advances the predictor state
   function automatic cct_rsp_type predict_chain_code(input cct_req_type rq);
      cct_rsp_type         rs;
      int                  r, c, k, dr, dc, hit_dr, hit_dc;
      logic [DIR_BITS-1:0] d, hit_dir, prev_dir;
      bit                  hit;
      rs = '0;
      rs.kind = KIND_END;
      if (rq.operation == OP_WRITE) begin
         // out of range writes are dropped but still acknowledged
         if (rq.pixel_row >= 1 && rq.pixel_row <= DEF_MAX_ROWS &&
             rq.pixel_col >= 1 && rq.pixel_col <= DEF_MAX_COLS)
            pixel_img[rq.pixel_row - 1][rq.pixel_col - 1] = rq.pixel_value;
         walk_phase = WALK_IDLE;
         rs.kind = KIND_WRITE_ACK;
      end else if (walk_phase == WALK_IDLE) begin
         // raster scan of the area in use, rows first
         walk_phase = WALK_DONE;
         for (r = 1; r <= area_rows && walk_phase != WALK_ACTIVE; r++)
            for (c = 1; c <= area_cols && walk_phase != WALK_ACTIVE; c++)
               if (pixel_img[r - 1][c - 1] != 0) begin
                  origin_row = r;
                  origin_col = c;
                  here_row = r;
                  here_col = c;
                  probe_from = DIR_W;
                  walk_phase = WALK_ACTIVE;
                  rs.kind = KIND_START;
                  rs.start_value = pixel_img[r - 1][c - 1];
                  rs.point_row = DIM_BITS'(r);
                  rs.point_col = DIM_BITS'(c);
               end
      end else if (walk_phase == WALK_ACTIVE) begin
         // counter-clockwise neighbour probe, frame and outside area read zero
         hit = 1'b0;
         hit_dir = DIR_E;
         hit_dr = 0;
         hit_dc = 0;
         for (k = 0; k < 8 && !hit; k++) begin
            d = probe_from + 3'd1 + k[DIR_BITS-1:0];
            case (d)
               DIR_E:   begin dr =  0; dc =  1; end
               DIR_NE:  begin dr = -1; dc =  1; end
               DIR_N:   begin dr = -1; dc =  0; end
               DIR_NW:  begin dr = -1; dc = -1; end
               DIR_W:   begin dr =  0; dc = -1; end
               DIR_SW:  begin dr =  1; dc = -1; end
               DIR_S:   begin dr =  1; dc =  0; end
               default: begin dr =  1; dc =  1; end
            endcase
            r = here_row + dr;
            c = here_col + dc;
            if (r >= 1 && c >= 1 && r <= area_rows && c <= area_cols &&
                pixel_img[r - 1][c - 1] != 0) begin
               hit = 1'b1;
               hit_dir = d;
               hit_dr = dr;
               hit_dc = dc;
            end
         end
         if (!hit) begin
            // isolated start pixel ends the walk
            walk_phase = WALK_DONE;
         end else begin
            here_row = here_row + hit_dr;
            here_col = here_col + hit_dc;
            // next search starts from the zero table entry of the previous direction
            prev_dir = hit_dir + 3'd7;
            case (prev_dir)
               DIR_NE, DIR_N:  probe_from = DIR_E;
               DIR_NW, DIR_W:  probe_from = DIR_N;
               DIR_SW, DIR_S:  probe_from = DIR_W;
               default:        probe_from = DIR_S;
            endcase
            rs.kind = KIND_CHAIN;
            rs.point_row = DIM_BITS'(here_row);
            rs.point_col = DIM_BITS'(here_col);
            rs.direction = hit_dir;
            if (here_row == origin_row && here_col == origin_col) begin
               rs.last = 1'b1;
               walk_phase = WALK_DONE;
            end
         end
      end
      return rs;
   endfunction

   task automatic report_field(input string name, input logic [8:0] want,
                               input logic [8:0] got);
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fail_count++;
   endtask

   // response side: random stalls, every accepted response checked against the oldest one owed
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_codes.size() == 0) begin
            $display("%0t: response with none expected, actual %p", $time, rsp_data);
            fail_count++;
         end else begin
            code_want = pending_codes.pop_front();
            if (rsp_data.kind !== code_want.kind)
               report_field("kind", code_want.kind, rsp_data.kind);
            if (rsp_data.start_value !== code_want.start_value)
               report_field("start_value", code_want.start_value, rsp_data.start_value);
            if (rsp_data.point_row !== code_want.point_row)
               report_field("point_row", code_want.point_row, rsp_data.point_row);
            if (rsp_data.point_col !== code_want.point_col)
               report_field("point_col", code_want.point_col, rsp_data.point_col);
            if (rsp_data.direction !== code_want.direction)
               report_field("direction", code_want.direction, rsp_data.direction);
            if (rsp_data.last !== code_want.last)
               report_field("last", code_want.last, rsp_data.last);
         end
      end
      rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // one request through the handshake; valid stays up when the next one follows at once
   task automatic send_request(input cct_req_type rq);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= rq;
      do @(posedge clock); while (!req_ready);
      pending_codes.push_back(predict_chain_code(rq));
      requests_sent++;
   endtask

   task automatic put_pixel(input int r, input int c, input int v);
      cct_req_type rq;
      rq.operation   = OP_WRITE;
      rq.pixel_row   = DIM_BITS'(r);
      rq.pixel_col   = DIM_BITS'(c);
      rq.pixel_value = VALUE_BITS'(v);
      send_request(rq);
   endtask

   // trace step, the unused fields carry garbage
   task automatic take_step();
      cct_req_type rq;
      rq.operation   = OP_STEP;
      rq.pixel_row   = DIM_BITS'($urandom_range(0, 511));
      rq.pixel_col   = DIM_BITS'($urandom_range(0, 511));
      rq.pixel_value = VALUE_BITS'($urandom_range(0, 255));
      send_request(rq);
   endtask

   // sender pauses until every owed response is back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (pending_codes.size() != 0) @(posedge clock);
   endtask

   // both area registers, back to back on the csr channel, only while idle
   task automatic set_area(input int rows, input int cols);
      logic [DIM_BITS-1:0] rv, cv;
      rv = DIM_BITS'(rows);
      cv = DIM_BITS'(cols);
      wait_for_drain();
      csr_valid <= 1'b1;
      csr_index <= REG_ROWS;
      csr_wdata <= rv;
      do @(posedge clock); while (!csr_ready);
      csr_index <= REG_COLS;
      csr_wdata <= cv;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      // zero reads as one, oversize saturates
      area_rows = (rv == 0) ? 1 : (rv > DEF_MAX_ROWS) ? DEF_MAX_ROWS : int'(rv);
      area_cols = (cv == 0) ? 1 : (cv > DEF_MAX_COLS) ? DEF_MAX_COLS : int'(cv);
   endtask

   // scan, then follow the boundary until it closes or the step budget runs out
   task automatic run_trace(input int cap);
      int n;
      take_step();
      for (n = 0; n < cap && walk_phase == WALK_ACTIVE; n++) begin
         if ($urandom_range(0, 49) == 0) begin
            // write in the middle of a walk, next step rescans
            put_pixel($urandom_range(1, area_rows), $urandom_range(1, area_cols),
                      $urandom_range(0, 255));
            take_step();
         end else if ($urandom_range(0, 79) == 0) begin
            // row count of the area may shrink under a running walk
            set_area($urandom_range(1, area_rows), area_cols);
         end
         take_step();
      end
      // one more step after the end
      take_step();
   endtask

   // zero every stored pixel that is visible in the area in use
   task automatic clear_area();
      int r, c;
      for (r = 1; r <= area_rows; r++)
         for (c = 1; c <= area_cols; c++)
            if (pixel_img[r - 1][c - 1] != 0) put_pixel(r, c, 0);
   endtask

   // full default area after reset with nothing written
   task automatic test_empty_store();
      take_step();
   endtask

   // object in the far corner of the full area, plus a dropped write
   task automatic test_corner_pixel();
      put_pixel(DEF_MAX_ROWS, DEF_MAX_COLS, 8'hff);
      put_pixel(0, DEF_MAX_COLS + 1, 8'h55);
      take_step();
      take_step();
      take_step();
   endtask

   // register saturation and pixels hidden outside the area in use
   task automatic test_area_extremes();
      set_area(0, 511);
      put_pixel(1, DEF_MAX_COLS, 8'h80);
      take_step();
      take_step();
      set_area(DEF_MAX_ROWS, 1);
      put_pixel(2, 1, 8'h40);
      take_step();
      take_step();
   endtask

   // diamond of diagonal neighbours, a write mid-walk and an area change mid-walk
   task automatic test_diamond_walk();
      set_area(8, 8);
      put_pixel(3, 4, 8'h11);
      put_pixel(4, 3, 8'h22);
      put_pixel(4, 5, 8'h33);
      put_pixel(5, 4, 8'h44);
      take_step();
      take_step();
      put_pixel(6, 6, 8'h01);
      take_step();
      take_step();
      set_area(4, 8);
      run_trace(16);
   endtask

   // random scenes: clear, draw a small blob, some noise, then walk it
   task automatic test_random_scenes();
      int scene, cfg, h, w, r0, c0, r, c, v;
      scene = 0;
      cfg = 0;
      while (requests_sent < REQUEST_TARGET) begin
         // idle pattern changes from scene to scene
         case (scene % 4)
            0:       begin send_idle_pct = 0;  stall_pct = 0;  end
            1:       begin send_idle_pct = 59; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 59; end
            default: begin send_idle_pct = 11; stall_pct = 11; end
         endcase
         if (scene % 3 == 0) begin
            // mostly small areas so the first-step scan stays cheap
            case (cfg % 6)
               1:       set_area(DEF_MAX_ROWS, $urandom_range(2, 12));
               3:       set_area($urandom_range(2, 12), DEF_MAX_COLS);
               4:       set_area($urandom_range(257, 511), $urandom_range(0, 1));
               5:       set_area(1, $urandom_range(3, 16));
               default: set_area($urandom_range(3, 20), $urandom_range(3, 20));
            endcase
            cfg++;
         end
         clear_area();
         h = $urandom_range(1, (area_rows < 5) ? area_rows : 5);
         w = $urandom_range(1, (area_cols < 5) ? area_cols : 5);
         r0 = $urandom_range(1, area_rows - h + 1);
         c0 = $urandom_range(1, area_cols - w + 1);
         for (r = r0; r < r0 + h; r++)
            for (c = c0; c < c0 + w; c++) begin
               // a few holes give ragged shapes
               v = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 255);
               put_pixel(r, c, v);
            end
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 6)) begin
               if ($urandom_range(0, 1) == 1)
                  take_step();
               else
                  put_pixel($urandom_range(0, 511), $urandom_range(0, 511),
                            $urandom_range(0, 255));
            end
         run_trace(64);
         scene++;
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_empty_store();
      test_corner_pixel();
      test_area_extremes();
      test_diamond_walk();
      test_random_scenes();
      // drain, then give the block a little time to show anything extra
      wait_for_drain();
      send_idle_pct = 0;
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending_codes.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

### files.f
+incdir+sv
sv/cct_pkg.sv
sv/cct_store.sv
sv/chain_code_boundary_tracer.sv
sim/tb_chain_code_boundary_tracer.sv
